[hw/rtl/aprq_pkg.sv]
`timescale 1ns / 1ps

package aprq_pkg;

  // Queue geometry
  localparam int DEPTH  = 1024;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = CNT_W + 1;

  // Field widths
  localparam int HANDLE_W = 32;
  localparam int OCC_W    = 11;
  localparam int ENTRY_W  = HANDLE_W + 1;

  // Command codes
  localparam logic CMD_SEND = 1'b0;
  localparam logic CMD_RECV = 1'b1;

  // Message kinds
  localparam logic KIND_NORMAL = 1'b0;
  localparam logic KIND_ALARM  = 1'b1;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_REFUSED = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;

  typedef struct packed {
    logic                command;
    logic [HANDLE_W-1:0] msg_handle;
    logic                msg_kind;
  } cmd_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [HANDLE_W-1:0] out_handle;
    logic                out_kind;
    logic [OCC_W-1:0]    occupancy;
    logic                alarm_count;
  } rsp_t;

  // Port of the entry store as driven by the controller
  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   addr;
    logic [ENTRY_W-1:0] wdata;
  } mem_req_t;

endpackage

[hw/rtl/alarm_priority_ring_queue.sv]
`timescale 1ns / 1ps

// Circular message queue with alarm insertion at the head.
// Request channel: a transaction is taken at a rising edge with start high
// and busy low; cmd carries command, msg_handle and msg_kind.
// Result channel: done is high for exactly one cycle with the result struct
// (status, out_handle, out_kind, occupancy, alarm_count); the receiver must
// take it then, there is no back-pressure.
// A send (normal, alarm or refused) and a receive from an empty queue
// report in the cycle after acceptance. A successful receive reports only
// after the S_READ state, since the entry comes from a single-port RAM with
// a registered read; busy is high while in S_READ.
// Throughput: sends one per cycle while busy is low; a successful receive
// holds busy in S_READ, so no new request is taken until its entry is read.
// Normal sends go to the tail, alarms go in front of the head; only one
// alarm can be queued. Full queue or a second alarm returns status refused.
// Reset clears head, count and the alarm flag at once; RAM contents are not
// cleared, entries outside the occupied window are never returned.
module alarm_priority_ring_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  aprq_pkg::cmd_t  cmd,
  output logic            done,
  output aprq_pkg::rsp_t  result
);

  aprq_pkg::mem_req_t                mem_req;
  logic [aprq_pkg::ENTRY_W-1:0]      mem_rdata;

  // Pointer/count/alarm control and result register
  aprq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .done      (done),
    .result    (result),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  // Entry store: {kind, handle} per slot
  aprq_ram #(
    .DEPTH (aprq_pkg::DEPTH),
    .WIDTH (aprq_pkg::ENTRY_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .addr  (mem_req.addr),
    .wdata (mem_req.wdata),
    .rdata (mem_rdata)
  );

endmodule

[hw/rtl/aprq_ram.sv]
`timescale 1ns / 1ps

// Single-port synchronous RAM, registered read data.
module aprq_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 33
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                           wdata,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata <= mem[addr];
    end
  end

endmodule

[hw/rtl/aprq_ctrl.sv]
`timescale 1ns / 1ps

// Pointer, count and alarm bookkeeping; drives the entry store.
module aprq_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  aprq_pkg::cmd_t                    cmd,
  output logic                              done,
  output aprq_pkg::rsp_t                    result,
  output aprq_pkg::mem_req_t                mem_req,
  input  logic [aprq_pkg::ENTRY_W-1:0]      mem_rdata
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  localparam logic [aprq_pkg::IDX_W-1:0] LAST_IDX =
    aprq_pkg::IDX_W'(aprq_pkg::DEPTH - 1);
  localparam logic [aprq_pkg::CNT_W-1:0] FULL_CNT =
    aprq_pkg::CNT_W'(aprq_pkg::DEPTH);
  localparam logic [aprq_pkg::SUM_W-1:0] DEPTH_SUM =
    aprq_pkg::SUM_W'(aprq_pkg::DEPTH);

  logic                          state;
  logic [aprq_pkg::IDX_W-1:0]    head;
  logic [aprq_pkg::CNT_W-1:0]    count;
  logic                          alarm;

  logic                          state_next;
  logic [aprq_pkg::IDX_W-1:0]    head_next;
  logic [aprq_pkg::CNT_W-1:0]    count_next;
  logic                          alarm_next;
  logic                          done_next;
  aprq_pkg::rsp_t                result_next;

  logic                          accept;
  logic                          full;
  logic                          empty;
  logic [aprq_pkg::IDX_W-1:0]    head_dec;
  logic [aprq_pkg::IDX_W-1:0]    head_inc;
  logic [aprq_pkg::SUM_W-1:0]    tail_sum;
  logic [aprq_pkg::IDX_W-1:0]    tail;

  assign busy   = (state == S_READ);
  assign accept = start && !busy;
  assign full   = (count == FULL_CNT);
  assign empty  = (count == '0);

  assign head_dec = (head == '0) ? LAST_IDX : head - 1'b1;
  assign head_inc = (head == LAST_IDX) ? '0 : head + 1'b1;
  // head + count stays below twice the depth: one compare and subtract
  assign tail_sum = aprq_pkg::SUM_W'(head) + aprq_pkg::SUM_W'(count);
  assign tail     = (tail_sum >= DEPTH_SUM) ?
                    aprq_pkg::IDX_W'(tail_sum - DEPTH_SUM) :
                    aprq_pkg::IDX_W'(tail_sum);

  always_comb begin
    state_next  = state;
    head_next   = head;
    count_next  = count;
    alarm_next  = alarm;
    done_next   = 1'b0;
    result_next = result;

    mem_req.we    = 1'b0;
    mem_req.addr  = head;
    mem_req.wdata = {cmd.msg_kind, cmd.msg_handle};

    case (state)
      S_IDLE: begin
        if (accept) begin
          result_next.out_handle = '0;
          result_next.out_kind   = aprq_pkg::KIND_NORMAL;
          result_next.status     = aprq_pkg::ST_OK;
          if (cmd.command == aprq_pkg::CMD_SEND) begin
            done_next = 1'b1;
            if (full) begin
              result_next.status = aprq_pkg::ST_REFUSED;
            end else if (cmd.msg_kind == aprq_pkg::KIND_ALARM) begin
              if (alarm) begin
                result_next.status = aprq_pkg::ST_REFUSED;
              end else begin
                mem_req.we    = 1'b1;
                mem_req.addr  = head_dec;
                mem_req.wdata = {aprq_pkg::KIND_ALARM, cmd.msg_handle};
                head_next     = head_dec;
                count_next    = count + 1'b1;
                alarm_next    = 1'b1;
              end
            end else begin
              mem_req.we    = 1'b1;
              mem_req.addr  = tail;
              mem_req.wdata = {aprq_pkg::KIND_NORMAL, cmd.msg_handle};
              count_next    = count + 1'b1;
            end
          end else begin
            if (empty) begin
              done_next          = 1'b1;
              result_next.status = aprq_pkg::ST_EMPTY;
            end else begin
              // read issued at head; finish when data returns
              head_next  = head_inc;
              count_next = count - 1'b1;
              state_next = S_READ;
            end
          end
          result_next.occupancy   = aprq_pkg::OCC_W'(count_next);
          result_next.alarm_count = alarm_next;
        end
      end
      S_READ: begin
        done_next              = 1'b1;
        result_next.status     = aprq_pkg::ST_OK;
        result_next.out_handle = mem_rdata[aprq_pkg::HANDLE_W-1:0];
        result_next.out_kind   = mem_rdata[aprq_pkg::ENTRY_W-1];
        if (mem_rdata[aprq_pkg::ENTRY_W-1] == aprq_pkg::KIND_ALARM) begin
          alarm_next = 1'b0;
        end
        result_next.occupancy   = aprq_pkg::OCC_W'(count);
        result_next.alarm_count = alarm_next;
        state_next              = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      count <= '0;
      alarm <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
      alarm <= alarm_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule
